// ===== rtl/core/bsf_pkg.sv =====
// bsf_pkg: shared types, constants and the header byte table of the bmp stream formatter
// used by every module under rtl/core; no dependencies
`timescale 1ns / 1ps

package bsf_pkg;

  // default size limits handed to the top level
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // field and register widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned PREC_W   = 5;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W    = 6;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PRECISION = 2'd2;

  // input item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // file format constants
  localparam logic [IDX_W-1:0] HDR_LEN        = 6'd54;
  localparam logic [IDX_W-1:0] PIXEL_BYTES    = 6'd3;
  localparam logic [31:0]      HDR_OFFSET     = 32'd54;
  localparam logic [31:0]      INFO_LEN       = 32'd40;
  localparam logic [BYTE_W-1:0] BITS_PER_PIXEL = 8'd24;
  localparam logic [BYTE_W-1:0] PLANE_COUNT   = 8'd1;
  localparam logic [BYTE_W-1:0] SIG_B         = 8'h42;
  localparam logic [BYTE_W-1:0] SIG_M         = 8'h4d;
  localparam logic [BYTE_W-1:0] BYTE_MAX      = 8'd255;
  localparam logic [PREC_W-1:0] PREC_NATIVE   = 5'd8;

  // control of one item waiting in the serializer
  typedef struct packed {
    logic       mode;
    logic [1:0] pad;
    logic       img_end;
  } bsf_item_t;

  // values that the header carries
  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] img_size;
    logic [31:0] file_size;
  } bsf_hdr_t;

  // one header byte, picked by position
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                                 input bsf_hdr_t hdr);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (idx)
      6'd0:  b = SIG_B;
      6'd1:  b = SIG_M;
      6'd2:  b = hdr.file_size[7:0];
      6'd3:  b = hdr.file_size[15:8];
      6'd4:  b = hdr.file_size[23:16];
      6'd5:  b = hdr.file_size[31:24];
      6'd10: b = HDR_OFFSET[7:0];
      6'd14: b = INFO_LEN[7:0];
      6'd18: b = hdr.width[7:0];
      6'd19: b = hdr.width[15:8];
      6'd20: b = hdr.width[23:16];
      6'd21: b = hdr.width[31:24];
      6'd22: b = hdr.height[7:0];
      6'd23: b = hdr.height[15:8];
      6'd24: b = hdr.height[23:16];
      6'd25: b = hdr.height[31:24];
      6'd26: b = PLANE_COUNT;
      6'd28: b = BITS_PER_PIXEL;
      6'd34: b = hdr.img_size[7:0];
      6'd35: b = hdr.img_size[15:8];
      6'd36: b = hdr.img_size[23:16];
      6'd37: b = hdr.img_size[31:24];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/bsf_if.sv =====
// bsf_pixel_if and bsf_byte_if: valid/ready channels of the bmp stream formatter
// depends on bsf_pkg for field widths
`timescale 1ns / 1ps

// pixel channel: start items and pixels
interface bsf_pixel_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [bsf_pkg::SAMPLE_W-1:0] red;
  logic [bsf_pkg::SAMPLE_W-1:0] green;
  logic [bsf_pkg::SAMPLE_W-1:0] blue;

  modport source (output valid, mode, red, green, blue, input ready);
  modport sink   (input valid, mode, red, green, blue, output ready);
endinterface

// byte channel: the file stream
interface bsf_byte_if;
  logic                       valid;
  logic                       ready;
  logic [bsf_pkg::BYTE_W-1:0] out_byte;
  logic                       last_of_item;
  logic                       end_of_image;

  modport source (output valid, out_byte, last_of_item, end_of_image, input ready);
  modport sink   (input valid, out_byte, last_of_item, end_of_image, output ready);
endinterface

// ===== rtl/core/bsf_lane.sv =====
// bsf_lane: one color lane, reduces a sample to 8 bits with round-half-up and clamp
// depends on bsf_pkg
`timescale 1ns / 1ps

module bsf_lane (
  input  logic                         clk,
  input  logic                         load,
  input  logic [bsf_pkg::PREC_W-1:0]   precision,
  input  logic [bsf_pkg::SAMPLE_W-1:0] sample,
  output logic [bsf_pkg::BYTE_W-1:0]   value
);

  logic [bsf_pkg::PREC_W-1:0]   shift;
  logic [bsf_pkg::PREC_W-1:0]   shift_m1;
  logic [bsf_pkg::SAMPLE_W-1:0] shifted;
  logic [bsf_pkg::SAMPLE_W-1:0] half;
  logic [bsf_pkg::SAMPLE_W:0]   rounded;
  logic [bsf_pkg::BYTE_W-1:0]   value_next;

  // shift out the extra precision, add the highest dropped bit
  always_comb begin
    shift    = precision - bsf_pkg::PREC_NATIVE;
    shift_m1 = shift - 5'd1;
    shifted  = sample >> shift;
    half     = sample >> shift_m1;
    if (precision > bsf_pkg::PREC_NATIVE) begin
      rounded = {1'b0, shifted} + {{bsf_pkg::SAMPLE_W{1'b0}}, half[0]};
    end else begin
      rounded = {1'b0, sample};
    end
    if (rounded > (bsf_pkg::SAMPLE_W + 1)'(bsf_pkg::BYTE_MAX)) begin
      value_next = bsf_pkg::BYTE_MAX;
    end else begin
      value_next = rounded[bsf_pkg::BYTE_W-1:0];
    end
  end

  // lane result register, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
    end
  end

endmodule

// ===== rtl/core/bsf_merge.sv =====
// bsf_merge: holds one item and serializes header or pixel bytes into the output register
// depends on bsf_pkg and bsf_byte_if
`timescale 1ns / 1ps

module bsf_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  bsf_pkg::bsf_item_t         item,
  input  logic [bsf_pkg::BYTE_W-1:0] blue,
  input  logic [bsf_pkg::BYTE_W-1:0] green,
  input  logic [bsf_pkg::BYTE_W-1:0] red,
  input  bsf_pkg::bsf_hdr_t          hdr,
  output logic                       free,
  bsf_byte_if.source                 file_byte
);

  logic                       job_valid;
  bsf_pkg::bsf_item_t         job;
  logic [bsf_pkg::IDX_W-1:0]  idx;
  logic [bsf_pkg::IDX_W-1:0]  total;
  logic                       is_last;
  logic                       out_load;
  logic [bsf_pkg::BYTE_W-1:0] byte_next;

  // byte count of the held item and the byte at the current position
  always_comb begin
    if (job.mode == bsf_pkg::MODE_START) begin
      total = bsf_pkg::HDR_LEN;
    end else begin
      total = bsf_pkg::PIXEL_BYTES + bsf_pkg::IDX_W'(job.pad);
    end
    is_last = (idx == total - 6'd1);
    if (job.mode == bsf_pkg::MODE_START) begin
      byte_next = bsf_pkg::hdr_byte(idx, hdr);
    end else begin
      unique case (idx)
        6'd0:    byte_next = blue;
        6'd1:    byte_next = green;
        6'd2:    byte_next = red;
        default: byte_next = '0;
      endcase
    end
  end

  // output register moves when empty or taken
  assign out_load = job_valid && (!file_byte.valid || file_byte.ready);
  assign free     = !job_valid || (out_load && is_last);

  // item control and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        job_valid <= 1'b1;
        idx       <= '0;
      end else if (out_load) begin
        if (is_last) begin
          job_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= item;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      file_byte.valid <= 1'b0;
    end else if (out_load) begin
      file_byte.valid <= 1'b1;
    end else if (file_byte.ready) begin
      file_byte.valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      file_byte.out_byte     <= byte_next;
      file_byte.last_of_item <= is_last;
      file_byte.end_of_image <= is_last && (job.mode == bsf_pkg::MODE_PIXEL) && job.img_end;
    end
  end

endmodule

// ===== rtl/core/bmp_24bit_stream_formatter_core.sv =====
// bmp_24bit_stream_formatter_core: top level, configuration, row and column counters
// depends on bsf_pkg, bsf_if, bsf_lane and bsf_merge
`timescale 1ns / 1ps

// Turns a stream of RGB pixels into the bytes of a 24-bit BMP file.
// pixel channel: mode 0 starts an image and yields the 54-byte header,
// mode 1 carries one pixel and yields blue, green, red, plus zero padding
// to a multiple of four bytes after the last pixel of a row.
// file_byte channel: one byte per transaction, last_of_item marks the final
// byte of an item, end_of_image the final byte of the last row.
// cfg port: cfg_write with cfg_index 0 width, 1 height, 2 sample precision;
// write only while no item is in flight.
// Taking an item registers it and its lane values; from there its first byte
// goes into the output register. One byte per cycle leaves it while file_byte
// is not stalled, 3 per pixel (3 to 6 at row end), 54 per start item; the
// next item is taken while the last byte of the current one is loaded.
// Three color lanes reduce the samples in parallel as an item is taken; the
// merge stage serializes them, which sets the rate.
// Reset clears the counters, the channels and the registers to width 1,
// height 1, precision 8. When file_byte is stalled the output register holds
// its byte and the pixel channel stops taking items while an item is held.
module bmp_24bit_stream_formatter_core #(
  parameter int unsigned MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsf_pkg::CFG_W-1:0]     cfg_data,
  bsf_pixel_if.sink                     pixel,
  bsf_byte_if.source                    file_byte
);

  localparam int unsigned DW_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DH_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CH_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned RB_W = DW_W + 3;
  localparam int unsigned PR_W = RB_W + DH_W;

  logic [bsf_pkg::DIM_W-1:0]  image_width;
  logic [bsf_pkg::DIM_W-1:0]  image_height;
  logic [bsf_pkg::PREC_W-1:0] sample_precision;
  logic [DW_W-1:0]            eff_w;
  logic [DH_W-1:0]            eff_h;
  logic [1:0]                 pad;
  logic [RB_W-1:0]            row_bytes;
  logic [PR_W-1:0]            product;
  logic [31:0]                img_size;
  logic [31:0]                file_size;
  logic [CW_W-1:0]            column_count;
  logic [CH_W-1:0]            row_count;
  logic                       row_end;
  logic                       img_end;
  logic                       accept;
  logic                       free;
  bsf_pkg::bsf_item_t         item;
  bsf_pkg::bsf_hdr_t          hdr;
  logic [bsf_pkg::BYTE_W-1:0] lane_blue;
  logic [bsf_pkg::BYTE_W-1:0] lane_green;
  logic [bsf_pkg::BYTE_W-1:0] lane_red;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= bsf_pkg::DIM_W'(1);
      image_height     <= bsf_pkg::DIM_W'(1);
      sample_precision <= bsf_pkg::PREC_NATIVE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsf_pkg::REG_IMAGE_WIDTH:      image_width      <= cfg_data[bsf_pkg::DIM_W-1:0];
        bsf_pkg::REG_IMAGE_HEIGHT:     image_height     <= cfg_data[bsf_pkg::DIM_W-1:0];
        bsf_pkg::REG_SAMPLE_PRECISION: sample_precision <= cfg_data[bsf_pkg::PREC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions: zero counts as one, saturate at the maximum
  always_comb begin
    if (image_width == '0) begin
      eff_w = DW_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = DW_W'(MAX_WIDTH);
    end else begin
      eff_w = DW_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = DH_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = DH_W'(MAX_HEIGHT);
    end else begin
      eff_h = DH_W'(image_height);
    end
  end

  // row padding equals width mod 4 for three bytes per pixel
  assign pad       = 2'(eff_w);
  assign row_bytes = RB_W'(eff_w) + RB_W'({eff_w, 1'b0}) + RB_W'(pad);
  assign product   = PR_W'(row_bytes) * PR_W'(eff_h);

  // image and file sizes, registered in two steps
  always_ff @(posedge clk) begin
    img_size  <= 32'(product);
    file_size <= img_size + bsf_pkg::HDR_OFFSET;
  end

  assign hdr.width     = 32'(eff_w);
  assign hdr.height    = 32'(eff_h);
  assign hdr.img_size  = img_size;
  assign hdr.file_size = file_size;

  // position of the incoming pixel in the image
  assign accept  = pixel.valid && free;
  assign row_end = (32'(column_count) + 32'd1) >= 32'(eff_w);
  assign img_end = row_end && ((32'(row_count) + 32'd1) >= 32'(eff_h));
  assign pixel.ready = free;

  assign item.mode    = pixel.mode;
  assign item.pad     = row_end ? pad : 2'd0;
  assign item.img_end = img_end;

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (pixel.mode == bsf_pkg::MODE_START) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= img_end ? '0 : row_count + CH_W'(1);
      end else begin
        column_count <= column_count + CW_W'(1);
      end
    end
  end

  // one lane per color
  bsf_lane u_lane_blue (
    .clk       (clk),
    .load      (accept),
    .precision (sample_precision),
    .sample    (pixel.blue),
    .value     (lane_blue)
  );

  bsf_lane u_lane_green (
    .clk       (clk),
    .load      (accept),
    .precision (sample_precision),
    .sample    (pixel.green),
    .value     (lane_green)
  );

  bsf_lane u_lane_red (
    .clk       (clk),
    .load      (accept),
    .precision (sample_precision),
    .sample    (pixel.red),
    .value     (lane_red)
  );

  // byte serializer and output register
  bsf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .item      (item),
    .blue      (lane_blue),
    .green     (lane_green),
    .red       (lane_red),
    .hdr       (hdr),
    .free      (free),
    .file_byte (file_byte)
  );

endmodule
